// ===== sv/fjsp_pkg.sv =====
package fjsp_pkg;

   // Characters that steer the parser
   localparam logic [7:0] CH_LBRACE    = 8'h7B;
   localparam logic [7:0] CH_RBRACE    = 8'h7D;
   localparam logic [7:0] CH_COLON     = 8'h3A;
   localparam logic [7:0] CH_COMMA     = 8'h2C;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_LOWER_U   = 8'h75;
   localparam logic [7:0] CH_LOWER_N   = 8'h6E;
   localparam logic [7:0] CH_LOWER_R   = 8'h72;
   localparam logic [7:0] CH_LOWER_T   = 8'h74;
   localparam logic [7:0] CH_LOWER_B   = 8'h62;
   localparam logic [7:0] CH_LOWER_F   = 8'h66;

   // Decoded control bytes
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_BS  = 8'h08;
   localparam logic [7:0] CH_FF  = 8'h0C;

   // Bytes skipped after a unicode escape
   localparam logic [2:0] HEX_SKIP_LEN = 3'd4;

   // Result queue geometry: one byte can cause up to three results
   localparam int RSP_DEPTH   = 4;
   localparam int RSP_PTR_W   = 2;
   localparam int RSP_CNT_W   = 3;
   localparam int MAX_RESULTS = 3;

   // Result kinds
   localparam logic [1:0] KIND_DATA    = 2'd0;
   localparam logic [1:0] KIND_STR_END = 2'd1;
   localparam logic [1:0] KIND_END     = 2'd2;

   // Stream end status
   localparam logic [1:0] STAT_BRACE     = 2'd0;
   localparam logic [1:0] STAT_MALFORMED = 2'd1;
   localparam logic [1:0] STAT_EARLY     = 2'd2;

   typedef enum logic [3:0] {
      M_PRE      = 4'd0,
      M_KEYWAIT  = 4'd1,
      M_KEY_STR  = 4'd2,
      M_KEY_ESC  = 4'd3,
      M_KEY_HEX  = 4'd4,
      M_AFTERKEY = 4'd5,
      M_VAL_STR  = 4'd6,
      M_VAL_ESC  = 4'd7,
      M_VAL_HEX  = 4'd8,
      M_AFTERVAL = 4'd9,
      M_DONE     = 4'd10
   } mode_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       stream_last;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic       in_value;
      logic [1:0] end_status;
      logic       run_last;
   } rsp_type;

   // Outcome of one parse step
   typedef struct packed {
      mode_type                       mode;
      logic [2:0]                     hex_left;
      logic [1:0]                     count;
      rsp_type [MAX_RESULTS-1:0]      res;
   } step_type;

   function automatic logic is_ws(input logic [7:0] b);
      return b inside {8'h20, [8'h09:8'h0D]};
   endfunction

   function automatic rsp_type mk_rsp(input logic [1:0] kind, input logic [7:0] data,
                                      input logic inval, input logic [1:0] status);
      rsp_type r;
      r.kind       = kind;
      r.data_byte  = data;
      r.in_value   = inval;
      r.end_status = status;
      r.run_last   = 1'b0;
      return r;
   endfunction

endpackage

// ===== sv/fjsp_step.sv =====
module fjsp_step
   import fjsp_pkg::*;
(
   input  mode_type   mode,
   input  logic [2:0] hex_left,
   input  req_type    req,
   output step_type   step
);

   logic [7:0] b;
   logic       last;
   mode_type   mode_a;
   logic [2:0] hex_a;
   logic [2:0] hex_dec;
   logic       a_vld;
   rsp_type    a_rsp;
   logic       inval;
   logic [7:0] esc_data;
   logic [1:0] n;

   assign b    = req.in_byte;
   assign last = req.stream_last;

   // Decode one byte against the current mode
   always_comb begin
      mode_a   = mode;
      hex_a    = hex_left;
      hex_dec  = hex_left - 3'd1;
      a_vld    = 1'b0;
      a_rsp    = '0;
      inval    = (mode == M_VAL_STR) || (mode == M_VAL_ESC) || (mode == M_VAL_HEX);
      esc_data = b;
      case (mode)
         M_PRE: begin
            if (b == CH_LBRACE) begin
               mode_a = M_KEYWAIT;
            end else if (!is_ws(b)) begin
               a_vld  = 1'b1;
               a_rsp  = mk_rsp(KIND_END, 8'h00, 1'b0, STAT_MALFORMED);
               mode_a = M_DONE;
            end
         end
         M_KEYWAIT, M_AFTERVAL: begin
            if (!((mode == M_AFTERVAL && b == CH_COMMA) || is_ws(b))) begin
               if (b == CH_RBRACE) begin
                  a_vld  = 1'b1;
                  a_rsp  = mk_rsp(KIND_END, 8'h00, 1'b0, STAT_BRACE);
                  mode_a = M_DONE;
               end else if (b == CH_QUOTE) begin
                  mode_a = M_KEY_STR;
               end else begin
                  a_vld  = 1'b1;
                  a_rsp  = mk_rsp(KIND_END, 8'h00, 1'b0, STAT_MALFORMED);
                  mode_a = M_DONE;
               end
            end
         end
         M_KEY_STR, M_VAL_STR: begin
            if (b == CH_QUOTE) begin
               a_vld  = 1'b1;
               a_rsp  = mk_rsp(KIND_STR_END, 8'h00, inval, 2'd0);
               mode_a = inval ? M_AFTERVAL : M_AFTERKEY;
            end else if (b == CH_BACKSLASH && !last) begin
               mode_a = inval ? M_VAL_ESC : M_KEY_ESC;
            end else begin
               a_vld = 1'b1;
               a_rsp = mk_rsp(KIND_DATA, b, inval, 2'd0);
            end
         end
         M_KEY_ESC, M_VAL_ESC: begin
            mode_a = inval ? M_VAL_STR : M_KEY_STR;
            a_vld  = 1'b1;
            case (b)
               CH_LOWER_N: esc_data = CH_LF;
               CH_LOWER_R: esc_data = CH_CR;
               CH_LOWER_T: esc_data = CH_TAB;
               CH_LOWER_B: esc_data = CH_BS;
               CH_LOWER_F: esc_data = CH_FF;
               CH_LOWER_U: begin
                  a_vld  = 1'b0;
                  hex_a  = HEX_SKIP_LEN;
                  mode_a = inval ? M_VAL_HEX : M_KEY_HEX;
               end
               default: esc_data = b;
            endcase
            a_rsp = mk_rsp(KIND_DATA, esc_data, inval, 2'd0);
         end
         M_KEY_HEX, M_VAL_HEX: begin
            hex_a = hex_dec;
            if (hex_dec == 3'd0) begin
               mode_a = inval ? M_VAL_STR : M_KEY_STR;
            end
         end
         M_AFTERKEY: begin
            if (!(b == CH_COLON || is_ws(b))) begin
               if (b == CH_QUOTE) begin
                  mode_a = M_VAL_STR;
               end else begin
                  a_vld  = 1'b1;
                  a_rsp  = mk_rsp(KIND_END, 8'h00, 1'b0, STAT_MALFORMED);
                  mode_a = M_DONE;
               end
            end
         end
         default: begin
            mode_a = mode;
         end
      endcase
   end

   // Pack results in order and close the stream on its final byte
   always_comb begin
      step          = '0;
      step.mode     = mode_a;
      step.hex_left = hex_a;
      n             = 2'd0;
      if (a_vld) begin
         step.res[n] = a_rsp;
         n           = n + 2'd1;
      end
      if (last) begin
         if (mode_a inside {M_KEY_STR, M_KEY_ESC, M_KEY_HEX}) begin
            step.res[n] = mk_rsp(KIND_STR_END, 8'h00, 1'b0, 2'd0);
            n           = n + 2'd1;
         end else if (mode_a inside {M_VAL_STR, M_VAL_ESC, M_VAL_HEX}) begin
            step.res[n] = mk_rsp(KIND_STR_END, 8'h00, 1'b1, 2'd0);
            n           = n + 2'd1;
         end
         if (mode_a < M_DONE) begin
            step.res[n] = mk_rsp(KIND_END, 8'h00, 1'b0, STAT_EARLY);
            n           = n + 2'd1;
         end
         step.mode     = M_PRE;
         step.hex_left = 3'd0;
      end
      if (n != 2'd0) begin
         step.res[n - 2'd1].run_last = 1'b1;
      end
      step.count = n;
   end

endmodule

// ===== sv/flat_json_string_object_parser.sv =====
// Streaming parser for one flat JSON object of string keys and string values.
// One byte is taken per cycle; the parse mode is updated in the same cycle and
// the byte's zero to three results go into a four-entry result queue, from
// which one result leaves per cycle while the output does not stall, the cycle
// after its byte was taken at the earliest. A byte is taken only while at most
// one result waits in the queue, so three slots are always free for it. With
// the output never stalled, bytes that cause at most one result each flow at
// one per cycle, and a byte with more results holds the input while the extra
// results leave. Every stream ends with exactly one end result, and the parser
// is back in its reset state after the byte marked last.
module flat_json_string_object_parser
   import fjsp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   mode_type               mode_ff,   mode_in;
   logic [2:0]             hex_ff,    hex_in;
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]   count_ff,  count_in;
   rsp_type                queue_ff [RSP_DEPTH];

   step_type               step;
   logic                   push;
   logic                   pop;
   logic [RSP_CNT_W-1:0]   push_n;

   fjsp_step u_step (
      .mode     (mode_ff),
      .hex_left (hex_ff),
      .req      (req_data),
      .step     (step)
   );

   // Take a byte only when three queue slots are free
   assign req_stall = (count_ff > RSP_CNT_W'(RSP_DEPTH - MAX_RESULTS));
   assign push      = req_valid && !req_stall;
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = queue_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign push_n    = push ? RSP_CNT_W'(step.count) : '0;

   // Advance parse state and queue pointers
   always_comb begin
      mode_in   = push ? step.mode : mode_ff;
      hex_in    = push ? step.hex_left : hex_ff;
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop);
      count_in  = count_ff + push_n - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= M_PRE;
         hex_ff    <= 3'd0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         mode_ff   <= mode_in;
         hex_ff    <= hex_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Write this beat's results into consecutive slots
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (push && (i < int'(step.count))) begin
            queue_ff[RSP_PTR_W'(wr_ptr_ff + RSP_PTR_W'(i))] <= step.res[i];
         end
      end
   end

endmodule

// ===== sv/fjsp_checker.sv =====
module fjsp_checker
   import fjsp_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // Queue is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // Stream end closes the results of its byte
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_END |-> rsp_data.run_last && !rsp_data.in_value)
      else $error("stream end not last result of its byte");

   // Only data beats carry a byte
   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != KIND_DATA |-> rsp_data.data_byte == 8'h00)
      else $error("non-data result carries a byte");

   // Status only on stream end
   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != KIND_END |-> rsp_data.end_status == 2'd0)
      else $error("status on a non-end result");

endmodule

bind flat_json_string_object_parser fjsp_checker u_fjsp_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
